// ===== hdl/afcs_pkg.sv =====
package afcs_pkg;

    localparam int REPLY_BYTES = 6;

    localparam logic [7:0] CMD_HELLO   = 8'h00;
    localparam logic [7:0] CMD_RED     = 8'h10;
    localparam logic [7:0] CMD_YELLOW  = 8'h12;
    localparam logic [7:0] CMD_BTN_ONE = 8'h30;
    localparam logic [7:0] CMD_BTN_TWO = 8'h32;
    localparam logic [7:0] CMD_LOAD    = 8'h40;
    localparam logic [7:0] CMD_TEMP    = 8'h42;

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
        logic       button_one_level;
        logic       button_two_level;
        logic [7:0] cpu_load;
        logic [7:0] cpu_temperature;
    } item_t;

    typedef struct packed {
        logic [7:0] own_addr;
        logic [7:0] requester;
        logic [7:0] cmd_echo;
        logic [7:0] data;
        logic [7:0] chk;
        logic       red_led;
        logic       yellow_led;
    } reply_t;

endpackage

// ===== hdl/addressed_frame_command_slave_top.sv =====
// The checksum byte passes the input register, then the reply loads into the serialiser.
// Throughput: one input per cycle unless stalled; a reply leaves one byte per ready cycle.
// A checksum byte waits in the input register while the previous reply is still being sent.
// Reset: aresetn synchronous, active low; clears byte count, LEDs, address and
// all valid flags; the frame store is not cleared.
module addressed_frame_command_slave_top #(
    parameter int FRAME_BYTES = 6
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // rx_byte[7:0], button_one_level[8], button_two_level[9], cpu_load[17:10],
    // cpu_temperature[25:18], zero[31:26]
    input  logic [31:0] s_axis_tdata,
    // op[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tx_byte[7:0], red_led[8], yellow_led[9], zero[15:10]
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    logic              in_vld_reg;
    afcs_pkg::item_t   in_reg;
    logic [7:0]        addr_reg;
    logic              advance;
    logic              is_final;
    logic              tx_busy;
    logic              reply_load;
    afcs_pkg::reply_t  reply;
    logic              s_take;

    assign advance       = in_vld_reg && !(is_final && tx_busy);
    assign s_axis_tready = !in_vld_reg || advance;
    assign s_take        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            addr_reg   <= '0;
        end else begin
            if (s_take) begin
                in_vld_reg <= 1'b1;
            end else if (advance) begin
                in_vld_reg <= 1'b0;
            end
            if (cfg_we) begin
                addr_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_reg.op               <= s_axis_tuser;
            in_reg.rx_byte          <= s_axis_tdata[7:0];
            in_reg.button_one_level <= s_axis_tdata[8];
            in_reg.button_two_level <= s_axis_tdata[9];
            in_reg.cpu_load         <= s_axis_tdata[17:10];
            in_reg.cpu_temperature  <= s_axis_tdata[25:18];
        end
    end

    afcs_rx #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_rx (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (advance),
        .item           (in_reg),
        .device_address (addr_reg),
        .is_final       (is_final),
        .reply_load     (reply_load),
        .reply          (reply)
    );

    afcs_tx u_tx (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .reply_load    (reply_load),
        .reply         (reply),
        .busy          (tx_busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && !advance |-> is_final && tx_busy)
        else $error("input held without a busy serialiser");

    a_held_item: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && !advance |=> in_vld_reg && $stable(in_reg))
        else $error("stalled transaction lost");

endmodule

// ===== hdl/afcs_rx.sv =====
module afcs_rx #(
    parameter int FRAME_BYTES = 6
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  afcs_pkg::item_t     item,
    input  logic [7:0]          device_address,
    output logic                is_final,
    output logic                reply_load,
    output afcs_pkg::reply_t    reply
);

    localparam int STORE_DEPTH = FRAME_BYTES - 1;
    localparam int CNT_W       = $clog2(FRAME_BYTES);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       sum_reg, sum_next;
    logic             red_reg, red_next;
    logic             yellow_reg, yellow_next;
    logic [7:0]       frame_reg [STORE_DEPTH];

    logic [7:0] src_byte, dst_byte, cmd_byte, d2_byte;
    logic [7:0] data;
    logic [7:0] cmd_echo;
    logic       cmd_known;
    logic       frame_ok;

    assign src_byte = frame_reg[0];
    assign dst_byte = frame_reg[1];

    generate
        if (STORE_DEPTH > 2) begin : g_cmd
            assign cmd_byte = frame_reg[2];
        end else begin : g_no_cmd
            assign cmd_byte = '0;
        end
        if (STORE_DEPTH > 4) begin : g_d2
            assign d2_byte = frame_reg[4];
        end else begin : g_no_d2
            assign d2_byte = '0;
        end
    endgenerate

    for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_store
        always_ff @(posedge aclk) begin
            if (advance && item.op == afcs_pkg::OP_BYTE && count_reg == CNT_W'(i)) begin
                frame_reg[i] <= item.rx_byte;
            end
        end
    end

    assign is_final = item.op == afcs_pkg::OP_BYTE && count_reg == CNT_W'(STORE_DEPTH);
    assign frame_ok = sum_reg == item.rx_byte && dst_byte == device_address;
    assign cmd_echo = cmd_byte + 8'd1;

    always_comb begin
        red_next    = red_reg;
        yellow_next = yellow_reg;
        data        = '0;
        cmd_known   = 1'b1;
        unique case (cmd_byte)
            afcs_pkg::CMD_HELLO:   data = '0;
            afcs_pkg::CMD_RED:     red_next = d2_byte != '0;
            afcs_pkg::CMD_YELLOW:  yellow_next = d2_byte != '0;
            afcs_pkg::CMD_BTN_ONE: data = {7'd0, ~item.button_one_level};
            afcs_pkg::CMD_BTN_TWO: data = {7'd0, ~item.button_two_level};
            afcs_pkg::CMD_LOAD:    data = item.cpu_load;
            afcs_pkg::CMD_TEMP:    data = item.cpu_temperature;
            default:               cmd_known = 1'b0;
        endcase
        if (!(advance && is_final && frame_ok && cmd_known)) begin
            red_next    = red_reg;
            yellow_next = yellow_reg;
        end
    end

    always_comb begin
        count_next = count_reg;
        sum_next   = sum_reg;
        reply_load = 1'b0;
        if (advance) begin
            if (item.op == afcs_pkg::OP_TIMEOUT) begin
                count_next = '0;
                sum_next   = '0;
            end else if (!is_final) begin
                count_next = count_reg + CNT_W'(1);
                sum_next   = sum_reg + item.rx_byte;
            end else begin
                count_next = '0;
                sum_next   = '0;
                reply_load = frame_ok && cmd_known;
            end
        end
    end

    always_comb begin
        reply.own_addr   = device_address;
        reply.requester  = src_byte;
        reply.cmd_echo   = cmd_echo;
        reply.data       = data;
        reply.chk        = device_address + src_byte + cmd_echo + data;
        reply.red_led    = red_next;
        reply.yellow_led = yellow_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            sum_reg    <= '0;
            red_reg    <= 1'b0;
            yellow_reg <= 1'b0;
        end else begin
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            red_reg    <= red_next;
            yellow_reg <= yellow_next;
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(STORE_DEPTH))
        else $error("byte count beyond frame length");

    a_final_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (is_final || item.op == afcs_pkg::OP_TIMEOUT) |=> count_reg == '0)
        else $error("byte count not cleared after frame end");

endmodule

// ===== hdl/afcs_tx.sv =====
module afcs_tx (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                reply_load,
    input  afcs_pkg::reply_t    reply,
    output logic                busy,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [15:0]         m_axis_tdata,
    output logic                m_axis_tlast
);

    localparam int IDX_W = $clog2(afcs_pkg::REPLY_BYTES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(afcs_pkg::REPLY_BYTES - 1);

    logic             busy_reg, busy_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    afcs_pkg::reply_t reply_reg;
    logic [7:0]       tx_byte;
    logic             take;

    assign busy          = busy_reg;
    assign m_axis_tvalid = busy_reg;
    assign m_axis_tlast  = idx_reg == IDX_LAST;
    assign m_axis_tdata  = {6'd0, reply_reg.yellow_led, reply_reg.red_led, tx_byte};
    assign take          = busy_reg && m_axis_tready;

    always_comb begin
        unique case (idx_reg)
            IDX_W'(0): tx_byte = reply_reg.own_addr;
            IDX_W'(1): tx_byte = reply_reg.requester;
            IDX_W'(2): tx_byte = reply_reg.cmd_echo;
            IDX_W'(3): tx_byte = '0;
            IDX_W'(4): tx_byte = reply_reg.data;
            IDX_W'(5): tx_byte = reply_reg.chk;
            default:   tx_byte = '0;
        endcase
    end

    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (reply_load) begin
            busy_next = 1'b1;
            idx_next  = '0;
        end else if (take) begin
            if (idx_reg == IDX_LAST) begin
                busy_next = 1'b0;
            end
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (reply_load) begin
            reply_reg <= reply;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        reply_load |-> !busy_reg)
        else $error("reply loaded while previous reply in flight");

    a_end_of_reply: assert property (@(posedge aclk) disable iff (!aresetn)
        take && m_axis_tlast |=> !busy_reg)
        else $error("serialiser still busy after last byte");

endmodule

// ===== verif/addressed_frame_command_slave_top_test.sv =====
`timescale 1ns / 1ps

module addressed_frame_command_slave_top_test;

    typedef struct packed {
        logic [7:0] tx;
        logic       last;
        logic       red;
        logic       yellow;
    } reply_beat_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [7:0]  cfg_wdata     = 8'h00;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = 32'h0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;

    afcs_pkg::item_t pending_items[$];
    reply_beat_t     reply_bytes_due[$];
    afcs_pkg::item_t offered;

    // slave model state
    logic [7:0]  frame_buf[5];
    int          frame_len = 0;
    logic        red_on    = 1'b0;
    logic        yellow_on = 1'b0;
    logic [7:0]  node_addr = 8'h00;

    int          errors    = 0;
    int          pushed    = 0;
    bit          steady    = 1'b0;
    int          hold_req  = 0;
    int          hold_ack  = 0;

    logic [7:0]  cmd_set[7] = '{afcs_pkg::CMD_HELLO, afcs_pkg::CMD_RED, afcs_pkg::CMD_YELLOW,
                                afcs_pkg::CMD_BTN_ONE, afcs_pkg::CMD_BTN_TWO,
                                afcs_pkg::CMD_LOAD, afcs_pkg::CMD_TEMP};

    addressed_frame_command_slave_top u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 aclk = ~aclk;

    function automatic int idle_len();
        int r;
        r = $urandom % 100;
        if (steady || r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic afcs_pkg::item_t random_item(input logic op, input logic [7:0] rx);
        afcs_pkg::item_t it;
        it.op               = op;
        it.rx_byte          = rx;
        it.button_one_level = 1'($urandom % 2);
        it.button_two_level = 1'($urandom % 2);
        it.cpu_load         = 8'($urandom);
        it.cpu_temperature  = 8'($urandom);
        return it;
    endfunction

    // collect one byte or clear on a timeout; on the checksum byte queue the six reply bytes, if any
    task automatic predict_reply(input afcs_pkg::item_t it);
        logic [7:0] sum;
        logic [7:0] cmd;
        logic [7:0] data;
        logic [7:0] rep[6];
        reply_beat_t beat;
        sum  = 8'h00;
        data = 8'h00;
        if (it.op == afcs_pkg::OP_TIMEOUT) begin
            frame_len = 0;
            return;
        end
        if (frame_len < 5) begin
            frame_buf[frame_len] = it.rx_byte;
            frame_len++;
            return;
        end
        frame_len = 0;
        for (int i = 0; i < 5; i++) sum = sum + frame_buf[i];
        if (sum != it.rx_byte || frame_buf[1] != node_addr) return;
        cmd = frame_buf[2];
        case (cmd)
            afcs_pkg::CMD_HELLO: ;
            afcs_pkg::CMD_RED: red_on = (frame_buf[4] != 8'h00);
            afcs_pkg::CMD_YELLOW: yellow_on = (frame_buf[4] != 8'h00);
            afcs_pkg::CMD_BTN_ONE: data = {7'b0, ~it.button_one_level};
            afcs_pkg::CMD_BTN_TWO: data = {7'b0, ~it.button_two_level};
            afcs_pkg::CMD_LOAD: data = it.cpu_load;
            afcs_pkg::CMD_TEMP: data = it.cpu_temperature;
            default: return;
        endcase
        rep[0] = node_addr;
        rep[1] = frame_buf[0];
        rep[2] = cmd + 8'h01;
        rep[3] = 8'h00;
        rep[4] = data;
        rep[5] = rep[0] + rep[1] + rep[2] + rep[3] + rep[4];
        for (int i = 0; i < afcs_pkg::REPLY_BYTES; i++) begin
            beat.tx     = rep[i];
            beat.last   = (i == afcs_pkg::REPLY_BYTES - 1);
            beat.red    = red_on;
            beat.yellow = yellow_on;
            reply_bytes_due.push_back(beat);
        end
    endtask

    // sender
    always @(posedge aclk) begin : drive_p
        int  gap;
        bit  nv;
        if (!aresetn) begin
            gap = 0;
            s_axis_tvalid <= 1'b0;
        end else begin
            nv = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                predict_reply(offered);
                gap = idle_len();
                nv  = 1'b0;
            end
            if (!nv) begin
                if (gap > 0) begin
                    gap--;
                end else if (pending_items.size() > 0) begin
                    offered = pending_items.pop_front();
                    s_axis_tdata <= {6'b0, offered.cpu_temperature, offered.cpu_load,
                                     offered.button_two_level, offered.button_one_level,
                                     offered.rx_byte};
                    s_axis_tuser <= offered.op;
                    nv = 1'b1;
                end
            end
            s_axis_tvalid <= nv;
        end
    end

    // receiver
    always @(posedge aclk) begin : sink_p
        int stall;
        int hold_cnt;
        if (!aresetn) begin
            stall    = 0;
            hold_cnt = 0;
            m_axis_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end else if (hold_req != hold_ack) begin
            hold_ack = hold_req;
            hold_cnt = 150;
            m_axis_tready <= 1'b0;
        end else if (stall > 0) begin
            stall--;
            m_axis_tready <= 1'b0;
        end else begin
            stall = idle_len();
            m_axis_tready <= (stall == 0);
        end
    end

    always @(posedge aclk) begin : check_p
        reply_beat_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (reply_bytes_due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected reply byte %h last %b", m_axis_tdata[7:0],
                             m_axis_tlast);
            end else begin
                want = reply_bytes_due.pop_front();
                if (want.tx !== m_axis_tdata[7:0] || want.last !== m_axis_tlast ||
                    want.red !== m_axis_tdata[8] || want.yellow !== m_axis_tdata[9]) begin
                    errors++;
                    if (errors <= 10)
                        $display("exp %h last %b red %b yel %b got %h last %b red %b yel %b",
                                 want.tx, want.last, want.red, want.yellow,
                                 m_axis_tdata[7:0], m_axis_tlast, m_axis_tdata[8],
                                 m_axis_tdata[9]);
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog_p
        int stuck;
        if (!aresetn || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            stuck = 0;
        end else begin
            stuck++;
            if (stuck >= 5000) begin
                $display("addressed_frame_command_slave_top_test: done, errors");
                $finish;
            end
        end
    end

    task automatic queue_frame(input logic [7:0] src, input logic [7:0] dst,
                               input logic [7:0] cmd, input logic [7:0] d1,
                               input logic [7:0] d2, input bit bad_sum,
                               input logic [7:0] load, input logic [7:0] temp);
        logic [7:0] b[6];
        afcs_pkg::item_t it;
        b[0] = src;
        b[1] = dst;
        b[2] = cmd;
        b[3] = d1;
        b[4] = d2;
        b[5] = src + dst + cmd + d1 + d2;
        if (bad_sum) b[5] = b[5] + 8'($urandom_range(1, 255));
        for (int i = 0; i < 6; i++) begin
            it = random_item(afcs_pkg::OP_BYTE, b[i]);
            if (i == 5) begin
                it.cpu_load        = load;
                it.cpu_temperature = temp;
            end
            pending_items.push_back(it);
            pushed++;
        end
    endtask

    task automatic queue_timeout();
        pending_items.push_back(random_item(afcs_pkg::OP_TIMEOUT, 8'($urandom)));
        pushed++;
    endtask

    task automatic random_traffic(input int n);
        int stop_at;
        int r;
        int k;
        logic [7:0] cmd;
        logic [7:0] d2;
        stop_at = pushed + n;
        while (pushed < stop_at) begin
            r   = $urandom % 100;
            cmd = cmd_set[$urandom % 7];
            d2  = ($urandom % 3 == 0) ? 8'h00 : 8'($urandom);
            if (r < 70) begin
                queue_frame(8'($urandom), node_addr, cmd, 8'($urandom), d2, 1'b0,
                            8'($urandom), 8'($urandom));
            end else if (r < 78) begin
                queue_frame(8'($urandom), node_addr + 8'($urandom_range(1, 255)), cmd,
                            8'($urandom), d2, 1'b0, 8'($urandom), 8'($urandom));
            end else if (r < 85) begin
                queue_frame(8'($urandom), node_addr, cmd, 8'($urandom), d2, 1'b1,
                            8'($urandom), 8'($urandom));
            end else if (r < 90) begin
                do cmd = 8'($urandom);
                while (cmd inside {afcs_pkg::CMD_HELLO, afcs_pkg::CMD_RED,
                                   afcs_pkg::CMD_YELLOW, afcs_pkg::CMD_BTN_ONE,
                                   afcs_pkg::CMD_BTN_TWO, afcs_pkg::CMD_LOAD,
                                   afcs_pkg::CMD_TEMP});
                queue_frame(8'($urandom), node_addr, cmd, 8'($urandom), d2, 1'b0,
                            8'($urandom), 8'($urandom));
            end else if (r < 96) begin
                k = $urandom_range(0, 5);
                for (int i = 0; i < k; i++) begin
                    pending_items.push_back(random_item(afcs_pkg::OP_BYTE, 8'($urandom)));
                    pushed++;
                end
                queue_timeout();
            end else begin
                queue_timeout();
            end
        end
    endtask

    task automatic settle();
        while (pending_items.size() != 0 || s_axis_tvalid || reply_bytes_due.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_address(input logic [7:0] a);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= a;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        node_addr = a;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        write_address(8'h00);

        // partial frame dropped by a timeout
        pending_items.push_back(random_item(afcs_pkg::OP_BYTE, 8'h12));
        pending_items.push_back(random_item(afcs_pkg::OP_BYTE, 8'h00));
        queue_timeout();
        queue_frame(8'hFF, 8'h00, afcs_pkg::CMD_TEMP, 8'hFF, 8'hFF, 1'b0, 8'h00, 8'hFF);
        queue_frame(8'h01, 8'h00, afcs_pkg::CMD_RED, 8'h00, 8'h01, 1'b1, 8'hFF, 8'h00);
        queue_frame(8'h02, 8'h00, 8'hFF, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00);
        queue_frame(8'h03, 8'h80, afcs_pkg::CMD_LOAD, 8'h55, 8'hAA, 1'b0, 8'hFF, 8'hFF);
        random_traffic(55);
        settle();

        // back-pressure: receiver holds off while the sender keeps offering
        write_address(8'hFF);
        steady <= 1'b1;
        hold_req++;
        random_traffic(45);
        settle();
        steady <= 1'b0;

        write_address(8'($urandom));
        random_traffic(45);
        settle();

        write_address(8'h80);
        random_traffic(45);
        settle();

        if (errors == 0) begin
            $display("addressed_frame_command_slave_top_test: done, clean");
        end else begin
            $display("addressed_frame_command_slave_top_test: done, errors");
        end
        $finish;
    end

endmodule
